/* sv/dpb_pkg.sv */
package dpb_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int PADDR_W    = 6;
  localparam int COEF_W     = 21;
  localparam int CAM_W      = 30;
  localparam int PROD_W     = COEF_W + CAM_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int COORD_W    = 32;

  localparam int IFOC_FRAC  = 24;
  localparam int ROT_FRAC   = 19;
  localparam int DEPTH_LIMIT = 5000;

  // register index = paddr[5:3]
  typedef enum logic [2:0] {
    REG_ROT_ROW0    = 3'd0,
    REG_ROT_ROW1    = 3'd1,
    REG_ROT_ROW2    = 3'd2,
    REG_WORLD_ORIG  = 3'd3,
    REG_PRINC_POINT = 3'd4,
    REG_INV_FOCAL   = 3'd5,
    REG_GRAY_INPUT  = 3'd6
  } dpb_reg_idx_t;

  typedef struct packed {
    logic [2:0][2:0][COEF_W-1:0] rot;
    logic [2:0][COEF_W-1:0]      origin;
    logic [15:0]                 cx;
    logic [15:0]                 cy;
    logic [23:0]                 ifx;
    logic [23:0]                 ify;
    logic                        gray;
  } dpb_cfg_t;

  // camera-frame point between projection and world transform
  typedef struct packed {
    logic                    vld;
    logic                    pv;
    logic signed [CAM_W-1:0] x;
    logic signed [CAM_W-1:0] y;
    logic signed [CAM_W-1:0] z;
    logic [7:0]              red;
    logic [7:0]              green;
    logic [7:0]              blue;
  } dpb_cam_t;

endpackage

/* sv/dpb_regs.sv */
module dpb_regs
  import dpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output dpb_cfg_t              cfg
);

  logic [62:0] rot0_r, rot1_r, rot2_r, origin_r;
  logic [31:0] pp_r;
  logic [47:0] ifoc_r;
  logic        gray_r;

  dpb_reg_idx_t idx;
  logic         wr_en;

  assign idx    = dpb_reg_idx_t'(paddr[5:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot0_r   <= '0;
      rot1_r   <= '0;
      rot2_r   <= '0;
      origin_r <= '0;
      pp_r     <= '0;
      ifoc_r   <= '0;
      gray_r   <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ROT_ROW0:    rot0_r   <= pwdata[62:0];
        REG_ROT_ROW1:    rot1_r   <= pwdata[62:0];
        REG_ROT_ROW2:    rot2_r   <= pwdata[62:0];
        REG_WORLD_ORIG:  origin_r <= pwdata[62:0];
        REG_PRINC_POINT: pp_r     <= pwdata[31:0];
        REG_INV_FOCAL:   ifoc_r   <= pwdata[47:0];
        REG_GRAY_INPUT:  gray_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROT_ROW0:    prdata = {1'b0, rot0_r};
      REG_ROT_ROW1:    prdata = {1'b0, rot1_r};
      REG_ROT_ROW2:    prdata = {1'b0, rot2_r};
      REG_WORLD_ORIG:  prdata = {1'b0, origin_r};
      REG_PRINC_POINT: prdata = {32'b0, pp_r};
      REG_INV_FOCAL:   prdata = {16'b0, ifoc_r};
      REG_GRAY_INPUT:  prdata = {63'b0, gray_r};
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cfg.rot[0][j] = rot0_r[COEF_W*j +: COEF_W];
      cfg.rot[1][j] = rot1_r[COEF_W*j +: COEF_W];
      cfg.rot[2][j] = rot2_r[COEF_W*j +: COEF_W];
      cfg.origin[j] = origin_r[COEF_W*j +: COEF_W];
    end
    cfg.cx   = pp_r[15:0];
    cfg.cy   = pp_r[31:16];
    cfg.ifx  = ifoc_r[23:0];
    cfg.ify  = ifoc_r[47:24];
    cfg.gray = gray_r;
  end

endmodule

/* sv/dpb_proj.sv */
module dpb_proj
  import dpb_pkg::*;
#(
  parameter int SAMPLE_STEP  = 8,
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [9:0]  col,
  input  logic [8:0]  row,
  input  logic [15:0] depth,
  input  logic [7:0]  chan0,
  input  logic [7:0]  chan1,
  input  logic [7:0]  chan2,
  input  dpb_cfg_t    cfg,
  output dpb_cam_t    cam
);

  // divisibility test: n % step == 0 iff (n * m) mod 2^F < m, m = ceil(2^F / step)
  localparam int SAMPLE_FRAC = 24;
  localparam int MAGIC_I     = ((1 << SAMPLE_FRAC) + SAMPLE_STEP - 1) / SAMPLE_STEP;
  localparam logic [24:0] MAGIC = 25'(MAGIC_I);
  localparam logic [12:0] WIDTH_LIM  = 13'(FRAME_WIDTH);
  localparam logic [12:0] HEIGHT_LIM = 13'(FRAME_HEIGHT);
  localparam logic signed [56:0] HALF_LSB = 57'sd1 <<< (IFOC_FRAC - 1);

  logic [34:0] col_prod, row_prod;
  logic        sample_hit, in_frame, depth_ok;

  // stage 0: sampling, pixel offsets, colour select
  logic              vld0_r, pv0_r;
  logic signed [17:0] du_r, dv_r, du_nxt, dv_nxt;
  logic [12:0]       d0_r;
  logic [7:0]        r0_r, g0_r, b0_r;

  // stage 1: offset times depth
  logic              vld1_r, pv1_r;
  logic signed [31:0] dud_r, dvd_r, dud_nxt, dvd_nxt;
  logic [12:0]       d1_r;
  logic [7:0]        r1_r, g1_r, b1_r;

  // stage 2: times inverse focal
  logic              vld2_r, pv2_r;
  logic signed [56:0] px_r, py_r, px_nxt, py_nxt;
  logic [12:0]       d2_r;
  logic [7:0]        r2_r, g2_r, b2_r;

  // stage 3: rounding
  dpb_cam_t          cam_r, cam_nxt;
  logic signed [56:0] pxr, pyr;

  always_comb begin
    col_prod   = {25'b0, col} * {10'b0, MAGIC};
    row_prod   = {26'b0, row} * {10'b0, MAGIC};
    sample_hit = ({1'b0, col_prod[SAMPLE_FRAC-1:0]} < MAGIC) &&
                 ({1'b0, row_prod[SAMPLE_FRAC-1:0]} < MAGIC);
    in_frame   = ({3'b0, col} < WIDTH_LIM) && ({4'b0, row} < HEIGHT_LIM);
    depth_ok   = (depth != 16'd0) && (depth < 16'(DEPTH_LIMIT));
    du_nxt     = $signed({4'b0, col, 4'b0}) - $signed({2'b0, cfg.cx});
    dv_nxt     = $signed({5'b0, row, 4'b0}) - $signed({2'b0, cfg.cy});
  end

  always_comb begin
    dud_nxt = du_r * $signed({1'b0, d0_r});
    dvd_nxt = dv_r * $signed({1'b0, d0_r});
    px_nxt  = dud_r * $signed({1'b0, cfg.ifx});
    py_nxt  = dvd_r * $signed({1'b0, cfg.ify});
  end

  always_comb begin
    pxr           = px_r + HALF_LSB;
    pyr           = py_r + HALF_LSB;
    cam_nxt.vld   = vld2_r;
    cam_nxt.pv    = pv2_r;
    cam_nxt.x     = pxr[IFOC_FRAC+CAM_W-1:IFOC_FRAC];
    cam_nxt.y     = pyr[IFOC_FRAC+CAM_W-1:IFOC_FRAC];
    cam_nxt.z     = $signed({13'b0, d2_r, 4'b0});
    cam_nxt.red   = r2_r;
    cam_nxt.green = g2_r;
    cam_nxt.blue  = b2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r    <= 1'b0;
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      cam_r.vld <= 1'b0;
    end else begin
      vld0_r    <= in_vld & sample_hit & in_frame;
      vld1_r    <= vld0_r;
      vld2_r    <= vld1_r;
      cam_r.vld <= cam_nxt.vld;
    end

    pv0_r <= depth_ok;
    du_r  <= du_nxt;
    dv_r  <= dv_nxt;
    d0_r  <= depth[12:0];
    r0_r  <= depth_ok ? chan0 : 8'd0;
    g0_r  <= depth_ok ? (cfg.gray ? chan0 : chan1) : 8'd0;
    b0_r  <= depth_ok ? (cfg.gray ? chan0 : chan2) : 8'd0;

    pv1_r <= pv0_r;
    dud_r <= dud_nxt;
    dvd_r <= dvd_nxt;
    d1_r  <= d0_r;
    r1_r  <= r0_r;
    g1_r  <= g0_r;
    b1_r  <= b0_r;

    pv2_r <= pv1_r;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    d2_r  <= d1_r;
    r2_r  <= r1_r;
    g2_r  <= g1_r;
    b2_r  <= b1_r;

    cam_r.pv    <= cam_nxt.pv;
    cam_r.x     <= cam_nxt.x;
    cam_r.y     <= cam_nxt.y;
    cam_r.z     <= cam_nxt.z;
    cam_r.red   <= cam_nxt.red;
    cam_r.green <= cam_nxt.green;
    cam_r.blue  <= cam_nxt.blue;
  end

  assign cam = cam_r;

endmodule

/* sv/dpb_xform.sv */
module dpb_xform
  import dpb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  dpb_cam_t                  cam,
  input  dpb_cfg_t                  cfg,
  output logic                      strobe,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y,
  output logic signed [COORD_W-1:0] point_z,
  output logic                      point_valid,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue
);

  localparam int WORLD_W = SUM_W - ROT_FRAC + 1;
  localparam logic signed [SUM_W-1:0]   HALF_LSB = SUM_W'(1) <<< (ROT_FRAC - 1);
  localparam logic signed [WORLD_W-1:0] SAT_MAX  = WORLD_W'(2147483647);
  localparam logic signed [WORLD_W-1:0] SAT_MIN  = ~SAT_MAX;

  logic signed [CAM_W-1:0] cvec [3];

  // stage 4: nine coefficient products
  logic                     vld4_r, pv4_r;
  logic signed [PROD_W-1:0] prod_r [3][3];
  logic signed [PROD_W-1:0] prod_nxt [3][3];
  logic [7:0]               r4_r, g4_r, b4_r;

  // stage 5: row sums
  logic                     vld5_r, pv5_r;
  logic signed [SUM_W-1:0]  sum_r [3];
  logic signed [SUM_W-1:0]  sum_nxt [3];
  logic [7:0]               r5_r, g5_r, b5_r;

  // stage 6: round, add origin, saturate
  logic signed [SUM_W-1:0]   rnd [3];
  logic signed [WORLD_W-1:0] world [3];
  logic signed [COORD_W-1:0] sat [3];

  logic                      strobe_r, pv_r;
  logic signed [COORD_W-1:0] px_r, py_r, pz_r;
  logic [7:0]                red_r, green_r, blue_r;

  always_comb begin
    cvec[0] = cam.x;
    cvec[1] = cam.y;
    cvec[2] = cam.z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = PROD_W'($signed(cfg.rot[i][j]) * cvec[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = SUM_W'(prod_r[i][0]) + SUM_W'(prod_r[i][1]) + SUM_W'(prod_r[i][2]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]   = sum_r[i] + HALF_LSB;
      world[i] = WORLD_W'($signed(rnd[i][SUM_W-1:ROT_FRAC])) +
                 WORLD_W'($signed({cfg.origin[i], 4'b0}));
      if (world[i] > SAT_MAX) begin
        sat[i] = SAT_MAX[COORD_W-1:0];
      end else if (world[i] < SAT_MIN) begin
        sat[i] = SAT_MIN[COORD_W-1:0];
      end else begin
        sat[i] = world[i][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r   <= 1'b0;
      vld5_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      vld4_r   <= cam.vld;
      vld5_r   <= vld4_r;
      strobe_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    pv4_r <= cam.pv;
    r4_r  <= cam.red;
    g4_r  <= cam.green;
    b4_r  <= cam.blue;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[i][j] <= prod_nxt[i][j];
      end
      sum_r[i] <= sum_nxt[i];
    end

    pv5_r <= pv4_r;
    r5_r  <= r4_r;
    g5_r  <= g4_r;
    b5_r  <= b4_r;

    // invalid depth gives an all-zero point
    pv_r    <= pv5_r;
    px_r    <= pv5_r ? sat[0] : '0;
    py_r    <= pv5_r ? sat[1] : '0;
    pz_r    <= pv5_r ? sat[2] : '0;
    red_r   <= r5_r;
    green_r <= g5_r;
    blue_r  <= b5_r;
  end

  assign strobe      = strobe_r;
  assign point_x     = px_r;
  assign point_y     = py_r;
  assign point_z     = pz_r;
  assign point_valid = pv_r;
  assign red         = red_r;
  assign green       = green_r;
  assign blue        = blue_r;

endmodule

/* sv/depth_pixel_backproject_top.sv */
// Depth pixel back-projection to world points.
// Input: one pixel word per cycle on in_* with start; busy is always low, so
//   a word is taken at every edge where start is high.
// Only pixels whose column and row are multiples of SAMPLE_STEP and that lie
//   inside FRAME_WIDTH x FRAME_HEIGHT produce a result; others are dropped.
// Output: out_strobe marks a result word on out_* for exactly one cycle;
//   the receiver cannot stall, and the pipeline never holds back.
// Throughput: one pixel per cycle, sustained. The pipeline has seven
//   register stages (sample test, offset x depth, x inverse focal, rounding,
//   rotation products, row sums, round/origin/saturate).
// Depth of 0 or 5000 mm and above yields a zero point with out_point_valid low.
// Config: APB port, register i at byte address 8*i, 64-bit data, no wait
//   states; write only while no pixel is in flight.
// Reset (synchronous, rst_n low) clears the config registers and valid flags
//   to zero and empties the pipeline; no result word is in flight after reset.
module depth_pixel_backproject_top
  import dpb_pkg::*;
#(
  parameter int SAMPLE_STEP  = 8,
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [9:0]                in_pixel_col,
  input  logic [8:0]                in_pixel_row,
  input  logic [15:0]               in_depth_mm,
  input  logic [7:0]                in_chan0,
  input  logic [7:0]                in_chan1,
  input  logic [7:0]                in_chan2,
  output logic                      out_strobe,
  output logic signed [COORD_W-1:0] out_point_x,
  output logic signed [COORD_W-1:0] out_point_y,
  output logic signed [COORD_W-1:0] out_point_z,
  output logic                      out_point_valid,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]     pwdata,
  output logic [CFG_DATA_W-1:0]     prdata,
  output logic                      pready
);

  dpb_cfg_t cfg;
  dpb_cam_t cam;

  assign busy = 1'b0;

  dpb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dpb_proj #(
    .SAMPLE_STEP  (SAMPLE_STEP),
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_proj (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start & ~busy),
    .col    (in_pixel_col),
    .row    (in_pixel_row),
    .depth  (in_depth_mm),
    .chan0  (in_chan0),
    .chan1  (in_chan1),
    .chan2  (in_chan2),
    .cfg    (cfg),
    .cam    (cam)
  );

  dpb_xform u_xform (
    .clk         (clk),
    .rst_n       (rst_n),
    .cam         (cam),
    .cfg         (cfg),
    .strobe      (out_strobe),
    .point_x     (out_point_x),
    .point_y     (out_point_y),
    .point_z     (out_point_z),
    .point_valid (out_point_valid),
    .red         (out_red),
    .green       (out_green),
    .blue        (out_blue)
  );

endmodule

/* dv/tb_depth_pixel_backproject_top.sv */
module tb_depth_pixel_backproject_top;
  import dpb_pkg::*;

  localparam int SAMPLE_STEP   = 8;
  localparam int FRAME_WIDTH   = 640;
  localparam int FRAME_HEIGHT  = 480;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam longint HALF_IFOC = longint'(1) << (IFOC_FRAC - 1);
  localparam longint HALF_ROT  = longint'(1) << (ROT_FRAC - 1);
  localparam int COEF_MAX = (1 << (COEF_W - 1)) - 1;
  localparam int COEF_MIN = -(1 << (COEF_W - 1));
  localparam int COEF_ONE = 1 << ROT_FRAC;

  typedef struct packed {
    logic [9:0]  col;
    logic [8:0]  row;
    logic [15:0] depth;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
  } pixel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      valid;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
  } point_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [9:0]                in_pixel_col;
  logic [8:0]                in_pixel_row;
  logic [15:0]               in_depth_mm;
  logic [7:0]                in_chan0;
  logic [7:0]                in_chan1;
  logic [7:0]                in_chan2;
  logic                      out_strobe;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic signed [COORD_W-1:0] out_point_z;
  logic                      out_point_valid;
  logic [7:0]                out_red;
  logic [7:0]                out_green;
  logic [7:0]                out_blue;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [CFG_DATA_W-1:0]     pwdata;
  logic [CFG_DATA_W-1:0]     prdata;
  logic                      pready;

  // shadow copy of the register file
  logic [62:0] rot_reg [3];
  logic [62:0] origin_reg;
  logic [31:0] pp_reg;
  logic [47:0] ifoc_reg;
  logic        gray_reg;

  pixel_t pending_pixels[$];
  point_t expected_points[$];
  int     mismatches;
  int     idle_pct;
  int     stall_cycles;

  depth_pixel_backproject_top #(
    .SAMPLE_STEP (SAMPLE_STEP),
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pixel_col   (in_pixel_col),
    .in_pixel_row   (in_pixel_row),
    .in_depth_mm    (in_depth_mm),
    .in_chan0       (in_chan0),
    .in_chan1       (in_chan1),
    .in_chan2       (in_chan2),
    .out_strobe     (out_strobe),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_z    (out_point_z),
    .out_point_valid(out_point_valid),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // world point for one pixel word; returns 0 when the pixel is dropped
  function automatic bit project_pixel(input pixel_t p, output point_t pt);
    longint du, dv, dd, acc, coef;
    longint cam [3];
    longint world [3];
    pt = '0;
    if ((p.col % SAMPLE_STEP) != 0 || (p.row % SAMPLE_STEP) != 0) return 1'b0;
    if (p.col >= FRAME_WIDTH || p.row >= FRAME_HEIGHT) return 1'b0;
    if (p.depth == 0 || p.depth >= DEPTH_LIMIT) return 1'b1;
    dd = p.depth;
    du = longint'(p.col) * 16 - longint'(pp_reg[15:0]);
    dv = longint'(p.row) * 16 - longint'(pp_reg[31:16]);
    cam[0] = (du * dd * longint'(ifoc_reg[23:0]) + HALF_IFOC) >>> IFOC_FRAC;
    cam[1] = (dv * dd * longint'(ifoc_reg[47:24]) + HALF_IFOC) >>> IFOC_FRAC;
    cam[2] = dd * 16;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        coef = $signed(rot_reg[i][COEF_W*j +: COEF_W]);
        acc += coef * cam[j];
      end
      coef = $signed(origin_reg[COEF_W*i +: COEF_W]);
      acc = ((acc + HALF_ROT) >>> ROT_FRAC) + 16 * coef;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      world[i] = acc;
    end
    pt.x     = world[0][31:0];
    pt.y     = world[1][31:0];
    pt.z     = world[2][31:0];
    pt.valid = 1'b1;
    pt.red   = p.c0;
    pt.green = gray_reg ? p.c0 : p.c1;
    pt.blue  = gray_reg ? p.c0 : p.c2;
    return 1'b1;
  endfunction

  function automatic logic [63:0] pack3(input int a, input int b, input int c);
    return {1'b0, c[COEF_W-1:0], b[COEF_W-1:0], a[COEF_W-1:0]};
  endfunction

  function automatic void add_pixel(input int col, input int row, input int depth,
                                    input int c0, input int c1, input int c2);
    pixel_t p;
    p.col   = col[9:0];
    p.row   = row[8:0];
    p.depth = depth[15:0];
    p.c0    = c0[7:0];
    p.c1    = c1[7:0];
    p.c2    = c2[7:0];
    pending_pixels = {pending_pixels, p};
  endfunction

  // mostly sample pixels inside the frame, some aligned outside, some noise
  function automatic void push_random_pixel();
    int unsigned pick;
    int col, row, depth;
    pick = $urandom_range(99);
    if (pick < 65) begin
      col = 8 * $urandom_range(FRAME_WIDTH / 8 - 1);
      row = 8 * $urandom_range(FRAME_HEIGHT / 8 - 1);
    end else if (pick < 75) begin
      col = 8 * $urandom_range(127);
      row = 8 * $urandom_range(63);
    end else begin
      col = $urandom_range(1023);
      row = $urandom_range(511);
    end
    pick = $urandom_range(99);
    if (pick < 70) depth = $urandom_range(DEPTH_LIMIT - 1, 1);
    else if (pick < 82) depth = $urandom_range(16'hFFFF, DEPTH_LIMIT);
    else if (pick < 88) depth = 0;
    else if (pick < 94) depth = DEPTH_LIMIT - 1 + $urandom_range(1);
    else depth = $urandom_range(16'hFFFF);
    add_pixel(col, row, depth, $urandom_range(255), $urandom_range(255),
              $urandom_range(255));
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ROT_ROW0:    rot_reg[0] = val[62:0];
      REG_ROT_ROW1:    rot_reg[1] = val[62:0];
      REG_ROT_ROW2:    rot_reg[2] = val[62:0];
      REG_WORLD_ORIG:  origin_reg = val[62:0];
      REG_PRINC_POINT: pp_reg     = val[31:0];
      REG_INV_FOCAL:   ifoc_reg   = val[47:0];
      REG_GRAY_INPUT:  gray_reg   = val[0];
      default: ;
    endcase
  endtask

  task automatic cfg_readback(input logic [2:0] idx);
    logic [63:0] want;
    logic [63:0] got;
    case (idx)
      REG_ROT_ROW0:    want = {1'b0, rot_reg[0]};
      REG_ROT_ROW1:    want = {1'b0, rot_reg[1]};
      REG_ROT_ROW2:    want = {1'b0, rot_reg[2]};
      REG_WORLD_ORIG:  want = {1'b0, origin_reg};
      REG_PRINC_POINT: want = {32'd0, pp_reg};
      REG_INV_FOCAL:   want = {16'd0, ifoc_reg};
      REG_GRAY_INPUT:  want = {63'd0, gray_reg};
      default:         want = '0;
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $display("%0t register %0d readback: expected %h actual %h", $time, idx, want, got);
      mismatches++;
    end
  endtask

  task automatic load_setup(input logic [63:0] r0, input logic [63:0] r1,
                            input logic [63:0] r2, input logic [63:0] org,
                            input logic [63:0] pp, input logic [63:0] ifoc,
                            input logic [63:0] gray);
    cfg_write(REG_ROT_ROW0, r0);
    cfg_write(REG_ROT_ROW1, r1);
    cfg_write(REG_ROT_ROW2, r2);
    cfg_write(REG_WORLD_ORIG, org);
    cfg_write(REG_PRINC_POINT, pp);
    cfg_write(REG_INV_FOCAL, ifoc);
    cfg_write(REG_GRAY_INPUT, gray);
    for (int k = REG_ROT_ROW0; k <= REG_GRAY_INPUT; k++) cfg_readback(3'(k));
    @(negedge clk);
  endtask

  // pixel stream drained, every point back, pipeline flushed of dropped words
  task automatic wait_drained();
    @(negedge clk);
    while (pending_pixels.size() != 0 || start || expected_points.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin : pixel_driver
    pixel_t nxt;
    point_t pt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy &&
          project_pixel({in_pixel_col, in_pixel_row, in_depth_mm,
                         in_chan0, in_chan1, in_chan2}, pt))
        expected_points = {expected_points, pt};
      if (start && busy) begin
        // word not taken yet, hold it
      end else if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_pixels.pop_front();
        start        <= 1'b1;
        in_pixel_col <= nxt.col;
        in_pixel_row <= nxt.row;
        in_depth_mm  <= nxt.depth;
        in_chan0     <= nxt.c0;
        in_chan1     <= nxt.c1;
        in_chan2     <= nxt.c2;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : point_monitor
    point_t got;
    point_t want;
    if (rst_n && out_strobe) begin
      got = {out_point_x, out_point_y, out_point_z, out_point_valid,
             out_red, out_green, out_blue};
      if (expected_points.size() == 0) begin
        $display("%0t unexpected point word: expected none actual %h", $time, got);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          $display("%0t point mismatch: expected %h actual %h", $time, want, got);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_pixel_col = '0;
    in_pixel_row = '0;
    in_depth_mm  = '0;
    in_chan0     = '0;
    in_chan1     = '0;
    in_chan2     = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rot_reg[0]   = '0;
    rot_reg[1]   = '0;
    rot_reg[2]   = '0;
    origin_reg   = '0;
    pp_reg       = '0;
    ifoc_reg     = '0;
    gray_reg     = 1'b0;
    mismatches   = 0;
    idle_pct     = 19;
    stall_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers at their reset values
    repeat (20) push_random_pixel();
    wait_drained();

    // identity rotation, typical camera
    load_setup(pack3(COEF_ONE, 0, 0), pack3(0, COEF_ONE, 0), pack3(0, 0, COEF_ONE),
               pack3(100, -200, 300), {32'd0, 16'(240 * 16), 16'(320 * 16)},
               {16'd0, 24'd31957, 24'd31957}, 64'd0);
    add_pixel(0, 0, 1, 0, 0, 0);
    add_pixel(632, 472, 4999, 255, 255, 255);
    add_pixel(320, 240, 1000, 1, 2, 3);
    add_pixel(8, 8, 2500, 8'hAA, 8'h55, 8'h0F);
    add_pixel(632, 0, 4999, 8'h55, 8'hAA, 8'hF0);
    add_pixel(0, 472, 1, 8'h80, 8'h01, 8'h7F);
    // invalid depths zero the whole word
    add_pixel(0, 0, 0, 255, 255, 255);
    add_pixel(320, 240, 5000, 9, 9, 9);
    add_pixel(320, 240, 65535, 255, 255, 255);
    add_pixel(632, 472, 0, 255, 255, 255);
    // off the sampling grid
    add_pixel(1, 0, 1000, 1, 1, 1);
    add_pixel(0, 1, 1000, 1, 1, 1);
    add_pixel(639, 479, 1000, 1, 1, 1);
    add_pixel(1023, 511, 65535, 255, 255, 255);
    // on the grid but outside the frame, then one in-frame corner pixel
    add_pixel(640, 0, 1000, 2, 2, 2);
    add_pixel(0, 480, 1000, 2, 2, 2);
    add_pixel(1016, 504, 4999, 2, 2, 2);
    add_pixel(0, 0, 4999, 8'h55, 8'hAA, 8'hF0);
    repeat (80) push_random_pixel();
    wait_drained();

    // most negative coefficients and origin, all-ones fields, grey mode
    load_setup(pack3(COEF_MIN, COEF_MIN, COEF_MIN) | 64'h8000_0000_0000_0000,
               pack3(COEF_MIN, COEF_MIN, COEF_MIN) | 64'h8000_0000_0000_0000,
               pack3(COEF_MIN, COEF_MIN, COEF_MIN) | 64'h8000_0000_0000_0000,
               pack3(COEF_MIN, COEF_MIN, COEF_MIN), '1, '1, '1);
    repeat (80) push_random_pixel();
    wait_drained();

    // most positive coefficients, back-to-back words with no gaps
    load_setup(pack3(COEF_MAX, COEF_MAX, COEF_MAX), pack3(COEF_MAX, COEF_MAX, COEF_MAX),
               pack3(COEF_MAX, COEF_MAX, COEF_MAX), pack3(COEF_MAX, COEF_MAX, COEF_MAX),
               64'd0, {16'd0, 48'hFFFFFF_FFFFFF}, 64'hFFFF_FFFF_FFFF_FFFE);
    // a write past the register list must not disturb anything
    cfg_write(REG_UNUSED, '1);
    @(negedge clk);
    idle_pct = 0;
    repeat (80) push_random_pixel();
    wait_drained();
    idle_pct = 19;

    // coefficients of -1 lsb, cx at zero, cy at its top
    load_setup('1, '1, '1, 64'd0, 64'h0000_0000_FFFF_0000,
               64'h0000_0000_00FF_FFFF, {32'd0, $urandom});
    repeat (80) push_random_pixel();
    wait_drained();

    for (int k = 0; k < 3; k++) begin
      load_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom});
      repeat (80) push_random_pixel();
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
